@@ design/flow_table_with_activity_aging_defines.svh @@
// Assertion macros shared by the flow table modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef FLOW_TABLE_WITH_ACTIVITY_AGING_DEFINES_SVH
`define FLOW_TABLE_WITH_ACTIVITY_AGING_DEFINES_SVH
`ifndef SYNTH
`define FTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FTA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FTA_ASSERT(lbl, prop, msg)
`define FTA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ design/fta_pkg.sv @@
// Types and constants of the flow table with activity aging.
// Used by fta_cell and flow_table_with_activity_aging; depends on nothing.
`default_nettype none

package fta_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam logic [31:0] DEFAULT_TIMEOUT   = 32'(60 * 60 * 24 * 7);
  localparam int unsigned COUNT_W           = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_SWEEP  = 2'd2
  } op_e;

  localparam logic [1:0] ADD_INSERTED = 2'd0;
  localparam logic [1:0] ADD_PRESENT  = 2'd1;
  localparam logic [1:0] ADD_FULL     = 2'd2;

  typedef struct packed {
    logic [63:0] addrs;
    logic [31:0] ports;
  } key_t;

  typedef struct packed {
    logic               valid;
    op_e                op;
    logic               hit;
    logic               free_seen;
    logic [COUNT_W-1:0] count;
  } tok_t;

endpackage

`default_nettype wire

@@ design/flow_table_with_activity_aging.sv @@
// Flow table with activity-bit aging: command port, timeout register, chain of entry cells.
// Depends on fta_pkg, fta_cell and the assertion macros header.
//
//   port group          direction  transfer
//   command + key       in         start && !busy
//   result fields       out        done_o, one cycle, cannot be held off
//   timeout register    in         cfg_we_i
//
// Lookups, adds and sweeping ticks hold busy while a token walks the cell chain one entry
// per cycle; then an add commits into the first free entry. A tick without a sweep, and an
// unused command, gives its result in the next cycle with busy staying low. Reset empties
// the table at once and loads the default timeout.
`default_nettype none
`include "flow_table_with_activity_aging_defines.svh"

module flow_table_with_activity_aging #(
  parameter int unsigned TABLE_ENTRIES = fta_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [31:0] dst_addr_i,
  input  wire logic [15:0] src_port_i,
  input  wire logic [15:0] dst_port_i,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  output logic             done_o,
  output logic             redirect_o,
  output logic [1:0]       add_status_o,
  output logic             swept_o,
  output logic [6:0]       removed_count_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e        state_q, state_d;
  fta_pkg::key_t key_q, key_d;
  fta_pkg::tok_t launch_q, launch_d;
  logic [31:0]   timeout_q, timeout_d;
  logic [31:0]   secs_q, secs_d;
  logic          done_q, done_d;
  logic          redirect_q, redirect_d;
  logic [1:0]    status_q, status_d;
  logic          swept_q, swept_d;
  logic [6:0]    removed_q, removed_d;
  logic          accept;
  logic          commit;
  fta_pkg::tok_t tail;

  fta_pkg::tok_t chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0] tok_valid;

  assign chain[0] = launch_q;
  assign tail     = chain[TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    fta_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .key_i    (key_q),
      .commit_i (commit),
      .tok_i    (chain[g]),
      .tok_o    (chain[g+1])
    );
  end

  for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_vld
    assign tok_valid[g] = chain[g].valid;
  end

  assign busy   = (state_q == ST_WALK);
  assign accept = start && !busy;

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    launch_d   = '0;
    timeout_d  = timeout_q;
    secs_d     = secs_q;
    done_d     = 1'b0;
    redirect_d = 1'b0;
    status_d   = 2'd0;
    swept_d    = 1'b0;
    removed_d  = 7'd0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d.addrs = {src_addr_i, dst_addr_i};
          key_d.ports = {src_port_i, dst_port_i};
          case (command_i)
            fta_pkg::CMD_LOOKUP: begin
              launch_d.valid = 1'b1;
              launch_d.op    = fta_pkg::OP_LOOKUP;
              state_d        = ST_WALK;
            end
            fta_pkg::CMD_ADD: begin
              launch_d.valid = 1'b1;
              launch_d.op    = fta_pkg::OP_ADD;
              state_d        = ST_WALK;
            end
            fta_pkg::CMD_TICK: begin
              if (secs_q <= 32'd1) begin
                launch_d.valid = 1'b1;
                launch_d.op    = fta_pkg::OP_SWEEP;
                state_d        = ST_WALK;
              end else begin
                secs_d = secs_q - 32'd1;
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (tail.valid) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          case (tail.op)
            fta_pkg::OP_LOOKUP: begin
              redirect_d = tail.hit;
            end
            fta_pkg::OP_ADD: begin
              if (tail.hit) begin
                status_d = fta_pkg::ADD_PRESENT;
              end else if (tail.free_seen) begin
                status_d = fta_pkg::ADD_INSERTED;
                commit   = 1'b1;
              end else begin
                status_d = fta_pkg::ADD_FULL;
              end
            end
            fta_pkg::OP_SWEEP: begin
              swept_d   = 1'b1;
              removed_d = tail.count;
              secs_d    = timeout_q;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      timeout_d = cfg_wdata_i;
      secs_d    = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      launch_q  <= '0;
      timeout_q <= fta_pkg::DEFAULT_TIMEOUT;
      secs_q    <= fta_pkg::DEFAULT_TIMEOUT;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      launch_q  <= launch_d;
      timeout_q <= timeout_d;
      secs_q    <= secs_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    redirect_q <= redirect_d;
    status_q   <= status_d;
    swept_q    <= swept_d;
    removed_q  <= removed_d;
  end

  assign done_o          = done_q;
  assign redirect_o      = redirect_q;
  assign add_status_o    = status_q;
  assign swept_o         = swept_q;
  assign removed_count_o = removed_q;

  `FTA_ASSERT(a_one_token, $onehot0(tok_valid), "more than one token in the chain")
  `FTA_ASSERT(a_tail_walk, tail.valid |-> (state_q == ST_WALK), "token left chain while idle")
  `FTA_ASSERT(a_walk_busy,
              (accept && (command_i == fta_pkg::CMD_LOOKUP || command_i == fta_pkg::CMD_ADD))
              |=> busy, "walking command did not raise busy")
  `FTA_ASSERT(a_one_group, done_o |-> ($countones({redirect_o, add_status_o != 2'd0, swept_o}) <= 1),
              "result carries fields of two commands")

endmodule

`default_nettype wire

@@ design/fta_cell.sv @@
// One flow table entry: key, valid and activity bits, and one stage of the token chain.
// Depends on fta_pkg and the assertion macros header.
`default_nettype none
`include "flow_table_with_activity_aging_defines.svh"

module fta_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fta_pkg::key_t key_i,
  input  wire logic          commit_i,
  input  wire fta_pkg::tok_t tok_i,
  output fta_pkg::tok_t      tok_o
);

  logic          valid_q, valid_d;
  logic          active_q, active_d;
  logic          pending_q, pending_d;
  fta_pkg::key_t key_q, key_d;
  fta_pkg::tok_t tok_q, tok_d;
  logic          match;

  always_comb begin
    valid_d   = valid_q;
    active_d  = active_q;
    pending_d = pending_q;
    key_d     = key_q;
    tok_d     = tok_i;
    match     = valid_q && (key_q == key_i);
    if (tok_i.valid) begin
      case (tok_i.op)
        fta_pkg::OP_LOOKUP: begin
          if (match) begin
            active_d = 1'b1;
          end
          tok_d.hit = tok_i.hit | match;
        end
        fta_pkg::OP_ADD: begin
          tok_d.hit       = tok_i.hit | match;
          pending_d       = !valid_q && !tok_i.free_seen;
          tok_d.free_seen = tok_i.free_seen | !valid_q;
        end
        fta_pkg::OP_SWEEP: begin
          if (valid_q && !active_q) begin
            valid_d = 1'b0;
            if (tok_i.count != fta_pkg::COUNT_MAX) begin
              tok_d.count = tok_i.count + 7'd1;
            end
          end
          active_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (commit_i && pending_q) begin
      valid_d   = 1'b1;
      active_d  = 1'b1;
      key_d     = key_i;
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      active_q  <= 1'b0;
      pending_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      valid_q   <= valid_d;
      active_q  <= active_d;
      pending_q <= pending_d;
      tok_q     <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign tok_o = tok_q;

  `FTA_ASSERT(a_commit_free, (commit_i && pending_q) |-> !valid_q, "commit into an occupied entry")
  `FTA_ASSERT_NEVER(a_commit_walk, commit_i && tok_i.valid, "commit while token in flight")
  `FTA_ASSERT(a_sweep_clears, (tok_i.valid && tok_i.op == fta_pkg::OP_SWEEP) |=> !active_q,
              "activity bit survived a sweep")

endmodule

`default_nettype wire
